@@ design/config_text_lexer_defines.svh @@
// assertion macros shared by the lexer modules
`ifndef CONFIG_TEXT_LEXER_DEFINES_SVH
`define CONFIG_TEXT_LEXER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/clt_pkg.sv @@
package clt_pkg;

  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;
  localparam logic [1:0] EV_EOF   = 2'd3;

  localparam logic [2:0] CL_INT    = 3'd0;
  localparam logic [2:0] CL_FLOAT  = 3'd1;
  localparam logic [2:0] CL_WORD   = 3'd2;
  localparam logic [2:0] CL_STRING = 3'd3;
  localparam logic [2:0] CL_SYMBOL = 3'd4;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_POINTS   = 3'd1;
  localparam logic [2:0] ERR_EXPS     = 3'd2;
  localparam logic [2:0] ERR_SIGN     = 3'd3;
  localparam logic [2:0] ERR_OPEN_STR = 3'd4;

  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic [1:0] ev;
    logic [2:0] cls;
    logic [7:0] ch;
    logic       first;
    logic [2:0] err;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [1:0]        cnt;
  } step_t;

endpackage

@@ design/config_text_lexer.sv @@
// an input transfer is registered in the input register, then its results are loaded into the result register
// throughput: one input item per cycle while out_ready is high and each item gives
// at most one result; an item with up to 3 results holds the output register until all are taken
// one item's classification is combinational between input and result registers
// reset (rst_n low, synchronous): lexer idle, flags cleared, both registers empty
module config_text_lexer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_res,
  output logic [2:0] out_token_class,
  output logic [7:0] out_char_value,
  output logic       out_first_char,
  output logic [2:0] out_error_code,
  output logic       out_last_result
);

  logic           inr_valid_r;
  logic [7:0]     char_r;
  logic           eoi_r;
  logic           step;
  logic           free;
  logic           load;
  clt_pkg::step_t bundle;

  // an item with no results only moves the state
  assign step     = inr_valid_r && ((bundle.cnt == 2'd0) || free);
  assign load     = step && (bundle.cnt != 2'd0);
  assign in_ready = !inr_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_valid_r <= 1'b0;
    end else if (in_ready) begin
      inr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r <= in_char_byte;
      eoi_r  <= in_end_of_input;
    end
  end

  clt_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .char_byte    (char_r),
    .end_of_input (eoi_r),
    .bundle       (bundle)
  );

  clt_resq u_resq (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .bundle          (bundle),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_token_class (out_token_class),
    .out_char_value  (out_char_value),
    .out_first_char  (out_first_char),
    .out_error_code  (out_error_code),
    .out_last_result (out_last_result)
  );

endmodule

@@ design/clt_core.sv @@
module clt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_byte,
  input  logic              end_of_input,
  output clt_pkg::step_t    bundle
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_E  = 8'h65;

  typedef enum logic [2:0] {
    M_IDLE,
    M_COMMENT,
    M_NUMBER,
    M_WORD,
    M_STRING,
    M_ERROR
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  flt_r, flt_nxt;
  logic  pnt_r, pnt_nxt;
  logic  exp_r, exp_nxt;
  logic  pexp_r, pexp_nxt;
  logic  await_r, await_nxt;

  function automatic clt_pkg::res_t mk(input logic [1:0] ev, input logic [2:0] cls,
                                       input logic [7:0] ch, input logic first,
                                       input logic [2:0] err);
    clt_pkg::res_t r;
    r.ev    = ev;
    r.cls   = cls;
    r.ch    = ch;
    r.first = first;
    r.err   = err;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
           || (c == CH_UNDER);
  endfunction

  logic [2:0] num_cls;
  logic [2:0] num_cls_nxt;

  assign num_cls = flt_r ? clt_pkg::CL_FLOAT : clt_pkg::CL_INT;

  always_comb begin
    clt_pkg::res_t [clt_pkg::MaxRes-1:0] res_v;
    logic [1:0] n;
    logic       do_idle;
    logic [7:0] c;

    c         = char_byte;
    res_v     = '0;
    n         = 2'd0;
    do_idle   = 1'b0;
    mode_nxt  = mode_r;
    flt_nxt   = flt_r;
    pnt_nxt   = pnt_r;
    exp_nxt   = exp_r;
    pexp_nxt  = pexp_r;
    await_nxt = await_r;
    num_cls_nxt = clt_pkg::CL_INT;

    if (end_of_input) begin
      case (mode_r)
        M_NUMBER: begin
          res_v[n] = mk(clt_pkg::EV_END, num_cls, 8'h00, 1'b0, clt_pkg::ERR_NONE);
          n = n + 2'd1;
        end
        M_WORD: begin
          res_v[n] = mk(clt_pkg::EV_END, clt_pkg::CL_WORD, 8'h00, 1'b0, clt_pkg::ERR_NONE);
          n = n + 2'd1;
        end
        M_STRING: begin
          res_v[n] = mk(clt_pkg::EV_ERROR, clt_pkg::CL_STRING, 8'h00, 1'b0,
                        clt_pkg::ERR_OPEN_STR);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      res_v[n] = mk(clt_pkg::EV_EOF, clt_pkg::CL_INT, 8'h00, 1'b0, clt_pkg::ERR_NONE);
      n = n + 2'd1;
      mode_nxt  = M_IDLE;
      flt_nxt   = 1'b0;
      pnt_nxt   = 1'b0;
      exp_nxt   = 1'b0;
      pexp_nxt  = 1'b0;
      await_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        M_IDLE: do_idle = 1'b1;
        M_COMMENT: begin
          if (c == CH_LF) mode_nxt = M_IDLE;
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            pexp_nxt = 1'b0;
            res_v[n] = mk(clt_pkg::EV_BYTE, num_cls, c, 1'b0, clt_pkg::ERR_NONE);
            n = n + 2'd1;
          end else if (c == CH_DOT) begin
            if (pnt_r) begin
              res_v[n] = mk(clt_pkg::EV_ERROR, num_cls, 8'h00, 1'b0, clt_pkg::ERR_POINTS);
              n = n + 2'd1;
              mode_nxt = M_ERROR;
              flt_nxt = 1'b0; pnt_nxt = 1'b0; exp_nxt = 1'b0;
              pexp_nxt = 1'b0; await_nxt = 1'b0;
            end else begin
              pnt_nxt  = 1'b1;
              flt_nxt  = 1'b1;
              pexp_nxt = 1'b0;
              res_v[n] = mk(clt_pkg::EV_BYTE, clt_pkg::CL_FLOAT, c, 1'b0, clt_pkg::ERR_NONE);
              n = n + 2'd1;
            end
          end else if ((c == CH_UP_E) || (c == CH_LO_E)) begin
            if (exp_r) begin
              res_v[n] = mk(clt_pkg::EV_ERROR, num_cls, 8'h00, 1'b0, clt_pkg::ERR_EXPS);
              n = n + 2'd1;
              mode_nxt = M_ERROR;
              flt_nxt = 1'b0; pnt_nxt = 1'b0; exp_nxt = 1'b0;
              pexp_nxt = 1'b0; await_nxt = 1'b0;
            end else begin
              exp_nxt  = 1'b1;
              flt_nxt  = 1'b1;
              pexp_nxt = 1'b1;
              res_v[n] = mk(clt_pkg::EV_BYTE, clt_pkg::CL_FLOAT, c, 1'b0, clt_pkg::ERR_NONE);
              n = n + 2'd1;
            end
          end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            if (!pexp_r) begin
              res_v[n] = mk(clt_pkg::EV_ERROR, num_cls, 8'h00, 1'b0, clt_pkg::ERR_SIGN);
              n = n + 2'd1;
              mode_nxt = M_ERROR;
              flt_nxt = 1'b0; pnt_nxt = 1'b0; exp_nxt = 1'b0;
              pexp_nxt = 1'b0; await_nxt = 1'b0;
            end else begin
              pexp_nxt = 1'b0;
              res_v[n] = mk(clt_pkg::EV_BYTE, num_cls, c, 1'b0, clt_pkg::ERR_NONE);
              n = n + 2'd1;
            end
          end else begin
            res_v[n] = mk(clt_pkg::EV_END, num_cls, 8'h00, 1'b0, clt_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            flt_nxt = 1'b0; pnt_nxt = 1'b0; exp_nxt = 1'b0;
            pexp_nxt = 1'b0; await_nxt = 1'b0;
            do_idle = 1'b1;
          end
        end
        M_WORD: begin
          if (is_word(c)) begin
            res_v[n] = mk(clt_pkg::EV_BYTE, clt_pkg::CL_WORD, c, 1'b0, clt_pkg::ERR_NONE);
            n = n + 2'd1;
          end else begin
            res_v[n] = mk(clt_pkg::EV_END, clt_pkg::CL_WORD, 8'h00, 1'b0, clt_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle  = 1'b1;
          end
        end
        M_STRING: begin
          if (c == CH_QUOTE) begin
            res_v[n] = mk(clt_pkg::EV_END, clt_pkg::CL_STRING, 8'h00, 1'b0, clt_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            flt_nxt = 1'b0; pnt_nxt = 1'b0; exp_nxt = 1'b0;
            pexp_nxt = 1'b0; await_nxt = 1'b0;
          end else begin
            res_v[n] = mk(clt_pkg::EV_BYTE, clt_pkg::CL_STRING, c, await_r, clt_pkg::ERR_NONE);
            n = n + 2'd1;
            await_nxt = 1'b0;
          end
        end
        M_ERROR: begin
        end
        default: begin
        end
      endcase

      // terminating byte is handled again as from idle
      if (do_idle) begin
        if ((c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR)) begin
          mode_nxt = M_IDLE;
        end else if (c == CH_HASH) begin
          mode_nxt = M_COMMENT;
        end else if (is_digit(c) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_DOT)) begin
          mode_nxt = M_NUMBER;
          flt_nxt  = (c == CH_MINUS) || (c == CH_DOT);
          pnt_nxt  = (c == CH_DOT);
          exp_nxt  = 1'b0;
          pexp_nxt = 1'b0;
          await_nxt = 1'b0;
          num_cls_nxt = flt_nxt ? clt_pkg::CL_FLOAT : clt_pkg::CL_INT;
          res_v[n] = mk(clt_pkg::EV_BYTE, num_cls_nxt, c, 1'b1, clt_pkg::ERR_NONE);
          n = n + 2'd1;
        end else if (is_word(c)) begin
          mode_nxt = M_WORD;
          res_v[n] = mk(clt_pkg::EV_BYTE, clt_pkg::CL_WORD, c, 1'b1, clt_pkg::ERR_NONE);
          n = n + 2'd1;
        end else if (c == CH_QUOTE) begin
          mode_nxt  = M_STRING;
          await_nxt = 1'b1;
        end else begin
          mode_nxt = M_IDLE;
          res_v[n] = mk(clt_pkg::EV_BYTE, clt_pkg::CL_SYMBOL, c, 1'b1, clt_pkg::ERR_NONE);
          n = n + 2'd1;
          res_v[n] = mk(clt_pkg::EV_END, clt_pkg::CL_SYMBOL, 8'h00, 1'b0, clt_pkg::ERR_NONE);
          n = n + 2'd1;
        end
      end
    end

    bundle.res = res_v;
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      flt_r   <= 1'b0;
      pnt_r   <= 1'b0;
      exp_r   <= 1'b0;
      pexp_r  <= 1'b0;
      await_r <= 1'b0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      flt_r   <= flt_nxt;
      pnt_r   <= pnt_nxt;
      exp_r   <= exp_nxt;
      pexp_r  <= pexp_nxt;
      await_r <= await_nxt;
    end
  end

`include "config_text_lexer_defines.svh"

  `CLT_ASSERT_NEXT(a_eoi_idle, step && end_of_input, mode_r == M_IDLE, "eoi left lexer busy")
  `CLT_ASSERT_NOW(a_err_silent, step && !end_of_input && (mode_r == M_ERROR), bundle.cnt == 2'd0, "error mode emitted")
  `CLT_ASSERT_NOW(a_eoi_count, step && end_of_input, (bundle.cnt == 2'd1) || (bundle.cnt == 2'd2), "bad eoi count")

endmodule

@@ design/clt_resq.sv @@
module clt_resq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  clt_pkg::step_t bundle,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_event_res,
  output logic [2:0]     out_token_class,
  output logic [7:0]     out_char_value,
  output logic           out_first_char,
  output logic [2:0]     out_error_code,
  output logic           out_last_result
);

  clt_pkg::step_t bund_r;
  logic           valid_r;
  logic [1:0]     idx_r;
  logic           last;
  clt_pkg::res_t  cur;

  assign last = (idx_r == (bund_r.cnt - 2'd1));
  assign free = !valid_r || (out_ready && last);
  assign cur  = bund_r.res[idx_r];

  assign out_valid       = valid_r;
  assign out_event_res   = cur.ev;
  assign out_token_class = cur.cls;
  assign out_char_value  = cur.ch;
  assign out_first_char  = cur.first;
  assign out_error_code  = cur.err;
  assign out_last_result = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (valid_r && out_ready) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= bundle;
    end
  end

`include "config_text_lexer_defines.svh"

  `CLT_ASSERT_NOW(a_load_free, load, free, "bundle overwritten before drained")
  `CLT_ASSERT_NOW(a_idx_range, valid_r, idx_r < bund_r.cnt, "result index past count")
  `CLT_ASSERT_NEXT(a_hold, valid_r && !out_ready, valid_r && $stable(idx_r), "stalled result moved")

endmodule
